[rtl/adcps_pkg.sv]
// ----------------------------------------------------------------------------
// adcps_pkg
// Shared types and constants of the ADC packet stream parser.
// ----------------------------------------------------------------------------
package adcps_pkg;

	typedef enum logic [2:0] {
		KIND_HEADER     = 3'd0,
		KIND_PREAMBLE   = 3'd1,
		KIND_ALARM      = 3'd2,
		KIND_SAMPLE     = 3'd3,
		KIND_BAD_MAGIC  = 3'd4,
		KIND_PACKET_END = 3'd5
	} kind_t;

	localparam int CFG_IDX_W = 4;
	localparam int TDATA_W   = 248;

	localparam logic [CFG_IDX_W-1:0] CFG_NA_ID = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NB_ID = 4'd1;

	localparam logic [15:0] NA_ID_RESET = 16'd20033;
	localparam logic [15:0] NB_ID_RESET = 16'd20034;
	localparam logic [15:0] MAGIC       = 16'h5053;   // "PS"

	// header byte offsets
	localparam logic [31:0] OFF_MAGIC   = 32'd1;
	localparam logic [31:0] OFF_ID      = 32'd3;
	localparam logic [31:0] OFF_LEN     = 32'd7;
	localparam logic [31:0] OFF_HDR_END = 32'd15;

	// body byte offsets
	localparam logic [31:0] OFF_STATUS   = 32'h03;
	localparam logic [31:0] OFF_ADC      = 32'h07;
	localparam logic [31:0] OFF_SEQ      = 32'h0F;
	localparam logic [31:0] OFF_LOLO     = 32'h1B;
	localparam logic [31:0] OFF_LO       = 32'h1F;
	localparam logic [31:0] OFF_HI       = 32'h23;
	localparam logic [31:0] OFF_HIHI     = 32'h27;
	localparam logic [31:0] NA_START     = 32'h18;
	localparam logic [31:0] NB_START     = 32'h28;

	typedef struct packed {
		logic [15:0] na_id;
		logic [15:0] nb_id;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic [31:0]        field_a;
		logic [31:0]        field_b;
		logic [63:0]        field_c;
		logic [31:0]        field_d;
		logic signed [23:0] sample_value;
		logic [30:0]        sample_index;
		logic [31:0]        packet_number;
		logic               end_of_packet;
	} result_t;

endpackage

[rtl/adc_packet_stream_parser_unit.sv]
// ----------------------------------------------------------------------------
// adc_packet_stream_parser_unit
// Parses a byte stream of ADC packets into header, preamble, alarm, sample,
// packet end and bad magic results.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one stream byte per transfer. m_* carries at most one result
//   per byte: m_tuser is the result kind, m_tlast closes a packet, m_tdata
//   holds the fields. cfg_* writes the NA and NB message id registers; write
//   it only while no bytes are in flight.
//   One byte is taken every cycle unless the receiver stalls; the input
//   register and the result register, which drives m_tvalid, are split by
//   a single pass of decode logic, so the rate is set by that one stage.
//   When the receiver stalls, the result register holds and the input
//   register takes a byte only while it is empty; further bytes wait on
//   s_tready. Bytes that give no result still pass through the input
//   register. Reset clears all packet state and the counters and loads the
//   default ids 20033 and 20034. After a bad magic, bytes are taken and
//   dropped until the next reset.
// ----------------------------------------------------------------------------
module adc_packet_stream_parser_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,    // stream_byte
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// field_a, field_b, field_c, field_d, sample_value, sample_index,
	// packet_number, one zero pad bit
	output logic [adcps_pkg::TDATA_W-1:0]   m_tdata,
	output logic [2:0]                      m_tuser,    // kind
	output logic                            m_tlast,    // end_of_packet
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [adcps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                     cfg_data
);
	import adcps_pkg::*;

	cfg_t       cfg;
	result_t    res;
	logic       emit;
	logic       take;
	logic       out_ready;
	logic [7:0] data_s1;

	adcps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	adcps_in_reg u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.out_ready (out_ready),
		.take      (take),
		.data_s1   (data_s1)
	);

	adcps_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.data_s1 (data_s1),
		.cfg     (cfg),
		.emit    (emit),
		.res     (res)
	);

	adcps_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (emit),
		.res       (res),
		.out_ready (out_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

`ifndef SYNTHESIS
	// an empty result register must never block the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_PACKET_END |-> m_tlast)
		else $error("packet end result without end flag");

	a_bad_magic_open: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_BAD_MAGIC |-> !m_tlast)
		else $error("bad magic result carries end flag");
`endif

endmodule

[rtl/adcps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// adcps_cfg_regs
// Message id registers written through the configuration channel.
// ----------------------------------------------------------------------------
module adcps_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [adcps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                     cfg_data,
	output adcps_pkg::cfg_t                 cfg
);
	import adcps_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.na_id <= NA_ID_RESET;
			cfg_q.nb_id <= NB_ID_RESET;
		end else if (cfg_valid) begin
			// drop writes to unknown indexes
			case (cfg_index)
				CFG_NA_ID: cfg_q.na_id <= cfg_data;
				CFG_NB_ID: cfg_q.nb_id <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[rtl/adcps_in_reg.sv]
// ----------------------------------------------------------------------------
// adcps_in_reg
// Input register of the byte stream; holds one byte while the result side stalls.
// ----------------------------------------------------------------------------
module adcps_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       out_ready,
	output logic       take,
	output logic [7:0] data_s1
);
	logic valid_s1;

	assign take     = valid_s1 && out_ready;
	assign s_tready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
		end
	end

endmodule

[rtl/adcps_parser.sv]
// ----------------------------------------------------------------------------
// adcps_parser
// Packet state and per-byte decode: header, preamble, alarms, samples, packet end and bad magic.
// ----------------------------------------------------------------------------
module adcps_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          data_s1,
	input  adcps_pkg::cfg_t     cfg,
	output logic                emit,
	output adcps_pkg::result_t  res
);
	import adcps_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_BODY,
		PH_HALT
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [31:0] off_q, off_d;
	logic [1:0]  mod3_q, mod3_d;          // body offset modulo 3
	logic [63:0] hdr_q, hdr_d;
	logic [15:0] id_q, id_d;
	logic [31:0] len_q, len_d;
	logic [63:0] fs_q, fs_d;
	logic [31:0] saved_q [3];
	logic [31:0] saved_d [3];
	logic [23:0] ss_q, ss_d;
	logic [30:0] scnt_q, scnt_d;
	logic [31:0] pcnt_q, pcnt_d;

	logic [63:0] hdr_next;
	logic [63:0] fs_next;
	logic [23:0] ss_next;
	logic        last;
	logic        na;
	logic        nb;
	logic        in_samples;
	logic        complete;

	assign hdr_next = {hdr_q[55:0], data_s1};
	assign fs_next  = {fs_q[55:0], data_s1};
	assign ss_next  = {ss_q[15:0], data_s1};
	assign last     = (off_q == len_q - 32'd1);
	assign na       = (id_q == cfg.na_id);
	assign nb       = !na && (id_q == cfg.nb_id);
	assign in_samples = na ? (off_q >= NA_START) : (off_q >= NB_START);
	// NA start is a multiple of 3, NB start is one above a multiple of 3
	assign complete   = na ? (mod3_q == 2'd2) : (mod3_q == 2'd0);

	always_comb begin
		phase_d = phase_q;
		off_d   = off_q;
		mod3_d  = mod3_q;
		hdr_d   = hdr_q;
		id_d    = id_q;
		len_d   = len_q;
		fs_d    = fs_q;
		saved_d = saved_q;
		ss_d    = ss_q;
		scnt_d  = scnt_q;
		pcnt_d  = pcnt_q;
		emit    = 1'b0;
		res     = '0;
		res.packet_number = pcnt_q;

		if (take) begin
			case (phase_q)
				PH_HEADER: begin
					hdr_d = hdr_next;
					if (off_q == OFF_MAGIC && hdr_next[15:0] != MAGIC) begin
						phase_d     = PH_HALT;
						off_d       = '0;
						emit        = 1'b1;
						res.kind    = KIND_BAD_MAGIC;
						res.field_a = {16'd0, hdr_next[15:0]};
					end else if (off_q == OFF_HDR_END) begin
						pcnt_d  = pcnt_q + 32'd1;
						off_d   = '0;
						mod3_d  = '0;
						scnt_d  = '0;
						ss_d    = '0;
						fs_d    = '0;
						phase_d = (len_q == 32'd0) ? PH_HEADER : PH_BODY;
						emit    = 1'b1;
						res.kind          = KIND_HEADER;
						res.field_a       = {16'd0, id_q};
						res.field_b       = len_q;
						res.field_c       = {32'd0, hdr_next[63:32]};
						res.field_d       = hdr_next[31:0];
						res.packet_number = pcnt_q + 32'd1;
						res.end_of_packet = (len_q == 32'd0);
					end else begin
						if (off_q == OFF_ID) begin
							id_d = hdr_next[15:0];
						end
						if (off_q == OFF_LEN) begin
							len_d = hdr_next[31:0];
						end
						off_d = off_q + 32'd1;
					end
				end
				PH_BODY: begin
					fs_d = fs_next;
					if (off_q == OFF_STATUS) begin
						saved_d[0] = fs_next[31:0];
					end else if (off_q == OFF_ADC) begin
						saved_d[1] = fs_next[31:0];
					end else if (off_q == OFF_SEQ) begin
						emit        = 1'b1;
						res.kind    = KIND_PREAMBLE;
						res.field_a = saved_q[0];
						res.field_b = saved_q[1];
						res.field_c = fs_next;
					end

					if (nb) begin
						if (off_q == OFF_LOLO) begin
							saved_d[0] = fs_next[31:0];
						end else if (off_q == OFF_LO) begin
							saved_d[1] = fs_next[31:0];
						end else if (off_q == OFF_HI) begin
							saved_d[2] = fs_next[31:0];
						end else if (off_q == OFF_HIHI) begin
							emit        = 1'b1;
							res.kind    = KIND_ALARM;
							res.field_a = saved_q[0];
							res.field_b = saved_q[1];
							res.field_c = {32'd0, saved_q[2]};
							res.field_d = fs_next[31:0];
						end
					end

					if ((na || nb) && in_samples) begin
						ss_d = ss_next;
						if (complete) begin
							emit             = 1'b1;
							res.kind         = KIND_SAMPLE;
							res.sample_value = ss_next;
							res.sample_index = scnt_q;
							scnt_d           = scnt_q + 31'd1;
						end
					end

					if (last) begin
						phase_d = PH_HEADER;
						off_d   = '0;
						mod3_d  = '0;
						if (!emit) begin
							emit     = 1'b1;
							res.kind = KIND_PACKET_END;
						end
						res.end_of_packet = 1'b1;
					end else begin
						off_d  = off_q + 32'd1;
						mod3_d = (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
					end
				end
				PH_HALT: ;   // ignore everything until reset
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			off_q    <= '0;
			mod3_q   <= '0;
			hdr_q    <= '0;
			id_q     <= '0;
			len_q    <= '0;
			fs_q     <= '0;
			saved_q  <= '{default: '0};
			ss_q     <= '0;
			scnt_q   <= '0;
			pcnt_q   <= '0;
		end else begin
			phase_q  <= phase_d;
			off_q    <= off_d;
			mod3_q   <= mod3_d;
			hdr_q    <= hdr_d;
			id_q     <= id_d;
			len_q    <= len_d;
			fs_q     <= fs_d;
			saved_q  <= saved_d;
			ss_q     <= ss_d;
			scnt_q   <= scnt_d;
			pcnt_q   <= pcnt_d;
		end
	end

endmodule

[rtl/adcps_out_reg.sv]
// ----------------------------------------------------------------------------
// adcps_out_reg
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
module adcps_out_reg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  adcps_pkg::result_t              res,
	output logic                            out_ready,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [adcps_pkg::TDATA_W-1:0]   m_tdata,
	output logic [2:0]                      m_tuser,
	output logic                            m_tlast
);
	import adcps_pkg::*;

	result_t res_q;
	logic    valid_q;

	assign out_ready = !valid_q || m_tready;
	assign m_tvalid  = valid_q;
	assign m_tuser   = res_q.kind;
	assign m_tlast   = res_q.end_of_packet;
	assign m_tdata   = {1'b0, res_q.packet_number, res_q.sample_index,
		res_q.sample_value, res_q.field_d, res_q.field_c, res_q.field_b,
		res_q.field_a};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && load) begin
			res_q <= res;
		end
	end

endmodule

[dv/adc_packet_stream_parser_unit_tb.sv]
// ----------------------------------------------------------------------------
// adc_packet_stream_parser_unit_tb
// Feeds packet byte streams into the parser and checks every result against
// a cycle-free parser model kept in the bench. Runs several message id
// settings, short and long bodies, unknown ids and, last, a bad magic.
// ----------------------------------------------------------------------------
module adc_packet_stream_parser_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import adcps_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [TDATA_W-1:0]    m_tdata;
	logic [2:0]            m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [15:0]           cfg_data  = '0;

	adc_packet_stream_parser_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// parser model state
	logic [15:0] id_na;
	logic [15:0] id_nb;
	bit          in_body;
	logic [31:0] pos;
	logic [63:0] hdr_sr;
	logic [15:0] msg_id;
	logic [31:0] body_len;
	logic [63:0] body_sr;
	logic [31:0] words [3];
	logic [23:0] smp_sr;
	logic [30:0] smp_cnt;
	logic [31:0] pkt_cnt;
	bit          stopped;

	logic [7:0] stream_bytes [$];
	result_t    due_results [$];

	int  errors        = 0;
	int  cycles        = 0;
	int  bytes_taken   = 0;
	int  results_seen  = 0;
	int  packets_sent  = 0;
	int  kind_seen [8];
	int  src_idle_pct  = 0;
	int  snk_idle_pct  = 0;
	int  src_gap       = 0;
	int  snk_gap       = 0;
	bit  src_hold      = 1'b0;

	task automatic report(input string msg);
		$display("MISMATCH @%0d: %0s", cycles, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report($sformatf("%0s got %h want %h", name, got, want));
	endtask

	// Advance the parser by one byte; returns 1 when the byte yields a result.
	function automatic bit parse_byte(input logic [7:0] b, output result_t r);
		logic [31:0] off;
		logic [31:0] start;
		bit          last;
		bit          na;
		bit          nb;
		bit          got;
		r   = '0;
		got = 1'b0;
		if (stopped)
			return 1'b0;
		off = pos;
		if (!in_body) begin
			hdr_sr = {hdr_sr[55:0], b};
			if (off == OFF_MAGIC && hdr_sr[15:0] != MAGIC) begin
				stopped = 1'b1;
				pos = '0;
				r.kind = KIND_BAD_MAGIC;
				r.field_a = {16'h0, hdr_sr[15:0]};
				r.packet_number = pkt_cnt;
				return 1'b1;
			end
			if (off == OFF_ID)
				msg_id = hdr_sr[15:0];
			if (off == OFF_LEN)
				body_len = hdr_sr[31:0];
			if (off == OFF_HDR_END) begin
				pkt_cnt++;
				pos = '0;
				smp_cnt = '0;
				smp_sr = '0;
				body_sr = '0;
				in_body = (body_len != 0);
				r.kind = KIND_HEADER;
				r.field_a = {16'h0, msg_id};
				r.field_b = body_len;
				r.field_c = {32'h0, hdr_sr[63:32]};
				r.field_d = hdr_sr[31:0];
				r.packet_number = pkt_cnt;
				r.end_of_packet = (body_len == 0);
				return 1'b1;
			end
			pos = off + 1;
			return 1'b0;
		end

		last = (off == body_len - 1);
		na = (msg_id == id_na);
		nb = !na && (msg_id == id_nb);
		body_sr = {body_sr[55:0], b};
		if (off == OFF_STATUS)
			words[0] = body_sr[31:0];
		else if (off == OFF_ADC)
			words[1] = body_sr[31:0];
		else if (off == OFF_SEQ) begin
			r.kind = KIND_PREAMBLE;
			r.field_a = words[0];
			r.field_b = words[1];
			r.field_c = body_sr;
			got = 1'b1;
		end
		if (nb) begin
			if (off == OFF_LOLO)
				words[0] = body_sr[31:0];
			else if (off == OFF_LO)
				words[1] = body_sr[31:0];
			else if (off == OFF_HI)
				words[2] = body_sr[31:0];
			else if (off == OFF_HIHI) begin
				r.kind = KIND_ALARM;
				r.field_a = words[0];
				r.field_b = words[1];
				r.field_c = {32'h0, words[2]};
				r.field_d = body_sr[31:0];
				got = 1'b1;
			end
		end
		if (na || nb) begin
			start = na ? NA_START : NB_START;
			if (off >= start) begin
				smp_sr = {smp_sr[15:0], b};
				if ((off - start) % 3 == 2) begin
					r = '0;
					r.kind = KIND_SAMPLE;
					r.sample_value = smp_sr;
					r.sample_index = smp_cnt;
					smp_cnt++;
					got = 1'b1;
				end
			end
		end
		if (got)
			r.packet_number = pkt_cnt;
		if (last) begin
			in_body = 1'b0;
			pos = '0;
			if (!got) begin
				r.kind = KIND_PACKET_END;
				r.packet_number = pkt_cnt;
				got = 1'b1;
			end
			r.end_of_packet = 1'b1;
		end else begin
			pos = off + 1;
		end
		return got;
	endfunction

	// byte driver
	always @(posedge clk) begin : drive_bytes
		logic       nv;
		logic [7:0] nd;
		result_t    r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			nv = s_tvalid;
			nd = s_tdata;
			if (s_tvalid && s_tready) begin
				bytes_taken++;
				if (parse_byte(s_tdata, r))
					due_results.push_back(r);
				nv = 1'b0;
			end
			if (!nv) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (!src_hold && stream_bytes.size() > 0) begin
					if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
						src_gap = $urandom_range(0, 12);
					end else begin
						nd = stream_bytes.pop_front();
						nv = 1'b1;
					end
				end
			end
			s_tvalid <= nv;
			s_tdata  <= nd;
		end
	end

	// result monitor
	always @(posedge clk) begin : watch_results
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				kind_seen[m_tuser]++;
				if (due_results.size() == 0) begin
					report($sformatf("result kind %0d with nothing pending", m_tuser));
				end else begin
					want = due_results.pop_front();
					check_field("kind", m_tuser, want.kind);
					check_field("field_a", m_tdata[31:0], want.field_a);
					check_field("field_b", m_tdata[63:32], want.field_b);
					check_field("field_c", m_tdata[127:64], want.field_c);
					check_field("field_d", m_tdata[159:128], want.field_d);
					check_field("sample_value", m_tdata[183:160],
						$unsigned(want.sample_value));
					check_field("sample_index", m_tdata[214:184], want.sample_index);
					check_field("packet_number", m_tdata[246:215], want.packet_number);
					check_field("end_of_packet", m_tlast, want.end_of_packet);
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				m_tready <= 1'b0;
			end else if (snk_idle_pct != 0 && $urandom_range(99) < snk_idle_pct) begin
				snk_gap = $urandom_range(0, 12);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				due_results.size());
			$display("adc_packet_stream_parser_unit_tb: done, errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_NA_ID)
			id_na = val;
		else if (idx == CFG_NB_ID)
			id_nb = val;
	endtask

	// Wait for the stream to drain and all results to arrive, then let
	// result-free bytes still in the pipe fall out.
	task automatic settle();
		do @(negedge clk); while (stream_bytes.size() != 0 || s_tvalid ||
			due_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [7:0] body_byte();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic queue_packet(input logic [15:0] id, input logic [31:0] len,
			input logic [31:0] secs, input logic [31:0] nsec);
		logic [127:0] hdr;
		hdr = {MAGIC, id, len, secs, nsec};
		for (int i = 15; i >= 0; i--)
			stream_bytes.push_back(hdr[i*8 +: 8]);
		for (int i = 0; i < len; i++)
			stream_bytes.push_back(body_byte());
		packets_sent++;
	endtask

	function automatic logic [31:0] pick_len();
		if ($urandom_range(39) == 0)
			return $urandom_range(200, 400);
		case ($urandom_range(9))
			0:       return 0;
			1:       return $urandom_range(1, 15);
			2:       return 16;
			3:       return $urandom_range(17, 39);
			default: return $urandom_range(40, 72);
		endcase
	endfunction

	function automatic logic [15:0] pick_id();
		case ($urandom_range(7))
			0, 1, 2: return id_na;
			3, 4, 5: return id_nb;
			6:       return ($urandom_range(1) != 0) ? 16'h0000 : 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Queue random packets until about nbytes are pending; optionally hold the
	// sender halfway until every pending result is out.
	task automatic random_packets(input int nbytes, input bit pause_midway);
		int total;
		total = 0;
		while (total < nbytes) begin
			total -= stream_bytes.size();
			queue_packet(pick_id(), pick_len(), $urandom, $urandom);
			total += stream_bytes.size();
		end
		if (pause_midway) begin
			do @(negedge clk); while (stream_bytes.size() > total / 2);
			src_hold = 1'b1;
			do @(negedge clk); while (s_tvalid || due_results.size() != 0);
			repeat (SETTLE_CYCLES) @(negedge clk);
			src_hold = 1'b0;
		end
		settle();
	endtask

	initial begin
		id_na    = NA_ID_RESET;
		id_nb    = NB_ID_RESET;
		in_body  = 1'b0;
		pos      = '0;
		hdr_sr   = '0;
		msg_id   = '0;
		body_len = '0;
		body_sr  = '0;
		words    = '{default: '0};
		smp_sr   = '0;
		smp_cnt  = '0;
		pkt_cnt  = '0;
		stopped  = 1'b0;
		kind_seen = '{default: 0};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty body, short bodies, sample on last byte, partial
		// trailing sample, unknown id
		src_idle_pct = 5;
		snk_idle_pct = 5;
		queue_packet(NA_ID_RESET, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_packet(16'h0000, 1, 32'h0, 32'h0);
		queue_packet(NA_ID_RESET, 16, 32'h8000_0001, 32'h7FFF_FFFE);
		queue_packet(NA_ID_RESET, 32'h1B, $urandom, $urandom);
		queue_packet(NB_ID_RESET, 32'h2B, $urandom, $urandom);
		queue_packet(NB_ID_RESET, 32'h29, $urandom, $urandom);
		queue_packet(16'hFFFF, 30, $urandom, $urandom);
		settle();

		write_reg(CFG_NA_ID, 16'h0000);
		write_reg(CFG_NB_ID, 16'hFFFF);
		src_idle_pct = 10;
		snk_idle_pct = 15;
		random_packets(30, 1'b1);

		// equal ids: NA takes precedence
		write_reg(CFG_NA_ID, 16'h1234);
		write_reg(CFG_NB_ID, 16'h1234);
		src_idle_pct = 0;
		snk_idle_pct = 20;
		random_packets(30, 1'b0);

		write_reg(CFG_NA_ID, 16'hFFFF);
		write_reg(CFG_NB_ID, 16'h0000);
		src_idle_pct = 15;
		snk_idle_pct = 0;
		random_packets(30, 1'b0);

		write_reg(CFG_NA_ID, 16'($urandom));
		write_reg(CFG_NB_ID, 16'($urandom));
		src_idle_pct = 8;
		snk_idle_pct = 8;
		random_packets(30, 1'b0);

		// back to defaults, full rate on both sides
		write_reg(CFG_NA_ID, NA_ID_RESET);
		write_reg(CFG_NB_ID, NB_ID_RESET);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		random_packets(30, 1'b0);

		// bad magic halts the parser for the rest of the run
		stream_bytes.push_back(MAGIC[15:8]);
		stream_bytes.push_back(8'h58);
		for (int i = 0; i < 20; i++)
			stream_bytes.push_back(8'($urandom));
		queue_packet(NA_ID_RESET, 27, $urandom, $urandom);
		settle();

		$display("covered %0d packets, %0d bytes, %0d results in %0d cycles",
			packets_sent, bytes_taken, results_seen, cycles);
		$display("kinds hdr/pre/alarm/sample/magic/end: %0d/%0d/%0d/%0d/%0d/%0d",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
			kind_seen[5]);
		if (errors == 0)
			$display("adc_packet_stream_parser_unit_tb: done, clean");
		else
			$display("adc_packet_stream_parser_unit_tb: done, errors");
		$finish;
	end

endmodule

[sim.f]
rtl/adcps_pkg.sv
rtl/adcps_cfg_regs.sv
rtl/adcps_in_reg.sv
rtl/adcps_parser.sv
rtl/adcps_out_reg.sv
rtl/adc_packet_stream_parser_unit.sv
dv/adc_packet_stream_parser_unit_tb.sv
